// ===== hw/rtl/ddbt_pkg.sv =====
// Shared types and constants for the display damage block tracker.
`default_nettype none
package ddbt_pkg;

  // Coordinate width of every position and size field.
  localparam int CW = 12;

  // Stream word widths (fields packed from bit 0, padded to whole bytes).
  localparam int IN_DW  = 56;
  localparam int IN_UW  = 2;
  localparam int OUT_DW = 56;

  // Saturation bounds for damage rectangles.
  localparam logic [CW-1:0] X_LIMIT = 12'd2048;
  localparam logic [CW-1:0] Y_LIMIT = 12'd4095;

  // Input item modes.
  localparam logic [1:0] MODE_DAMAGE = 2'd0;
  localparam logic [1:0] MODE_SAMPLE = 2'd1;
  localparam logic [1:0] MODE_FLUSH  = 2'd2;

  // Result kinds.
  localparam logic KIND_ACK  = 1'b0;
  localparam logic KIND_RECT = 1'b1;

  // Control broadcast to the span ring.
  typedef struct packed {
    logic          sh;       // rotate every cell one place toward the head
    logic          clr;      // close the span that wraps from head to tail
    logic          ld;       // write the head cell
    logic          ld_open;
    logic [CW-1:0] ld_top;
  } ring_ctl_t;

endpackage
`default_nettype wire

// ===== hw/rtl/ddbt_cell.sv =====
// One span cell: open flag and top row of one block, loaded from its neighbor.
`default_nettype none
module ddbt_cell (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire ddbt_pkg::ring_ctl_t     ctl,
  input  wire logic                    ld_sel,
  input  wire logic                    nb_open,
  input  wire logic [ddbt_pkg::CW-1:0] nb_top,
  output logic                         span_open,
  output logic [ddbt_pkg::CW-1:0]      span_top
);
  import ddbt_pkg::*;

  logic          open_r;
  logic [CW-1:0] top_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 1'b0;
    end else if (ctl.sh) begin
      open_r <= nb_open;
    end else if (ctl.ld && ld_sel) begin
      open_r <= ctl.ld_open;
    end
  end

  // top row carries no reset: it is only read while the open flag is set
  always_ff @(posedge clk) begin
    if (ctl.sh) begin
      top_r <= nb_top;
    end else if (ctl.ld && ld_sel) begin
      top_r <= ctl.ld_top;
    end
  end

  assign span_open = open_r;
  assign span_top  = top_r;

endmodule
`default_nettype wire

// ===== hw/rtl/ddbt_ring.sv =====
// Ring of span cells; cell 0 is the head, the head wraps back into the tail.
`default_nettype none
module ddbt_ring #(
  parameter int NCELL = 64
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire ddbt_pkg::ring_ctl_t     ctl,
  output logic                         head_open,
  output logic [ddbt_pkg::CW-1:0]      head_top
);
  import ddbt_pkg::*;

  logic          open_w [NCELL];
  logic [CW-1:0] top_w  [NCELL];
  logic          nb_open_w [NCELL];
  logic [CW-1:0] nb_top_w  [NCELL];

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    if (i == NCELL - 1) begin : g_tail
      // drop the head's span on the way around when clearing
      assign nb_open_w[i] = open_w[0] & ~ctl.clr;
      assign nb_top_w[i]  = top_w[0];
    end else begin : g_mid
      assign nb_open_w[i] = open_w[i+1];
      assign nb_top_w[i]  = top_w[i+1];
    end

    ddbt_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .ld_sel    (i == 0),
      .nb_open   (nb_open_w[i]),
      .nb_top    (nb_top_w[i]),
      .span_open (open_w[i]),
      .span_top  (top_w[i])
    );
  end

  assign head_open = open_w[0];
  assign head_top  = top_w[0];

endmodule
`default_nettype wire

// ===== hw/rtl/display_damage_block_tracker.sv =====
// Top level of the display damage block tracker: box merge, span ring control, output register.
//
// Damage reports merge into one dirty bounding box. Each one is acknowledged
// on the output in the cycle after it is accepted, so damage words stream at one
// word per cycle while the output register can take a result. Per-block open
// spans live in a ring of MAX_BLOCKS cells that rotates one cell per cycle while
// a sample or flush turns it and no output stall holds it. Only the head cell
// is read or written, and a register tracks the first column of the head block.
// A sample holds off the input while the ring turns d places, where d (0 to
// MAX_BLOCKS-1) is the number of places the ring must turn to bring the
// sampled block to the head, and while it waits for the output register when a
// span closes. A scan that walks blocks left to right turns the ring one place
// per sample. Samples at or beyond column MAX_BLOCKS*BLOCK_WIDTH and mode 3 are
// dropped on accept. A flush holds the input while it first turns the ring until
// the box's left block is at the head (up to MAX_BLOCKS-1 turns), then starts
// the walk and turns the ring one full revolution, emitting open spans in column
// order and closing every span as it wraps. It finishes in ST_FIN, which emits
// the last rectangle with tlast set and clears the box. Each rectangle is held in
// a register so the final one can be marked. Output backpressure stalls the
// ring, never drops data.
`default_nettype none
module display_damage_block_tracker #(
  parameter int BLOCK_WIDTH = 32,
  parameter int MAX_BLOCKS  = 64
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // input stream
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  // pos_x[11:0], pos_y[23:12], size_w[35:24], size_h[47:36], differs[48], zero[55:49]
  input  wire logic [ddbt_pkg::IN_DW-1:0]  in_tdata,
  // mode[1:0]
  input  wire logic [ddbt_pkg::IN_UW-1:0]  in_tuser,
  // result stream
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  // was_empty[0], rect_left[12:1], rect_top[24:13], rect_right[36:25],
  // rect_bottom[48:37], zero[55:49]
  output logic [ddbt_pkg::OUT_DW-1:0]      out_tdata,
  // kind[0]
  output logic [0:0]                       out_tuser,
  output logic                             out_tlast
);
  import ddbt_pkg::*;

  // wide enough for any column, a block base plus one block, and the ring span
  localparam int XW = $clog2(MAX_BLOCKS * BLOCK_WIDTH + 8192);
  localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam logic [XW-1:0] COL_LIMIT = XW'(MAX_BLOCKS * BLOCK_WIDTH);
  localparam logic [XW-1:0] BW_X      = XW'(BLOCK_WIDTH);
  localparam logic [IW-1:0] CNT_LAST  = IW'(MAX_BLOCKS - 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SMP  = 3'd1;  // turn ring to sampled block, then act
  localparam logic [2:0] ST_FSK  = 3'd2;  // turn ring to the box's left block
  localparam logic [2:0] ST_FWK  = 3'd3;  // one revolution: emit and close spans
  localparam logic [2:0] ST_FIN  = 3'd4;  // emit the held rectangle, clear box

  // unpack input word
  logic [CW-1:0] in_px, in_py, in_sw, in_sh;
  logic          in_diff;
  logic [1:0]    in_mode;
  assign in_px   = in_tdata[11:0];
  assign in_py   = in_tdata[23:12];
  assign in_sw   = in_tdata[35:24];
  assign in_sh   = in_tdata[47:36];
  assign in_diff = in_tdata[48];
  assign in_mode = in_tuser;

  logic [2:0]    st_r, st_nxt;
  logic [CW-1:0] box_l_r, box_t_r, box_r_r, box_b_r;
  logic [CW-1:0] box_l_nxt, box_t_nxt, box_r_nxt, box_b_nxt;
  logic [XW-1:0] hb_r, hb_nxt;
  logic [IW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] x_r, x_nxt;
  logic [CW-1:0] px_r, py_r;
  logic          diff_r;
  logic          pend_vld_r, pend_vld_nxt;
  logic [CW-1:0] pend_l_r, pend_t_r, pend_rt_r;
  logic [CW-1:0] pend_l_nxt, pend_t_nxt, pend_rt_nxt;
  logic          out_vld_r;
  logic          out_kind_r, out_we_r, out_last_r;
  logic [CW-1:0] out_l_r, out_t_r, out_rt_r, out_b_r;

  ring_ctl_t     ctl;
  logic          head_open;
  logic [CW-1:0] head_top;

  logic          out_free, in_acc, box_empty, rot;
  logic          push, push_kind, push_we, push_last;
  logic [CW-1:0] push_l, push_t, push_rt, push_b;

  // damage rectangle after saturation
  logic [CW:0]   dmg_rsum, dmg_bsum;
  logic [CW-1:0] dmg_l, dmg_r, dmg_b;
  logic          dmg_empty;

  // flush walk helpers
  logic          fl_emit, fl_go, fin_go;

  function automatic logic [XW-1:0] ext(input logic [CW-1:0] v);
    return XW'(v);
  endfunction

  // column lies in the block now held by the head cell
  function automatic logic at_head(input logic [CW-1:0] v, input logic [XW-1:0] hb);
    return (ext(v) >= hb) && (ext(v) < hb + BW_X);
  endfunction

  // right edge of a block rectangle, cut at the box's right column
  function automatic logic [CW-1:0] edge_rt(input logic [CW-1:0] x,
                                            input logic [CW-1:0] br);
    logic [CW-1:0] d;
    logic [XW-1:0] xb;
    d  = br - x;
    xb = ext(x) + BW_X;
    if (br <= x) begin
      return x;
    end else if (d < CW'(BLOCK_WIDTH)) begin
      return br;
    end else begin
      return xb[CW-1:0];
    end
  endfunction

  assign out_free  = !out_vld_r || out_tready;
  assign in_tready = (st_r == ST_IDLE) && out_free;
  assign in_acc    = in_tvalid && in_tready;
  assign box_empty = (box_t_r == box_b_r) || (box_l_r == box_r_r);

  assign dmg_rsum  = {1'b0, in_px} + {1'b0, in_sw};
  assign dmg_bsum  = {1'b0, in_py} + {1'b0, in_sh};
  assign dmg_l     = (in_px > X_LIMIT) ? X_LIMIT : in_px;
  assign dmg_r     = (dmg_rsum > {1'b0, X_LIMIT}) ? X_LIMIT : dmg_rsum[CW-1:0];
  assign dmg_b     = (dmg_bsum > {1'b0, Y_LIMIT}) ? Y_LIMIT : dmg_bsum[CW-1:0];
  assign dmg_empty = (in_py == dmg_b) || (dmg_l == dmg_r);

  // open span at the head that this flush must report
  assign fl_emit = !box_empty && at_head(x_r, hb_r) && (x_r < box_r_r) && head_open;
  // stall only when a held rectangle has nowhere to go
  assign fl_go   = !fl_emit || !pend_vld_r || out_free;
  assign fin_go  = !pend_vld_r || out_free;

  always_comb begin
    st_nxt      = st_r;
    box_l_nxt   = box_l_r;
    box_t_nxt   = box_t_r;
    box_r_nxt   = box_r_r;
    box_b_nxt   = box_b_r;
    cnt_nxt     = cnt_r;
    x_nxt       = x_r;
    pend_vld_nxt = pend_vld_r;
    pend_l_nxt  = pend_l_r;
    pend_t_nxt  = pend_t_r;
    pend_rt_nxt = pend_rt_r;
    rot         = 1'b0;
    ctl         = '0;
    push        = 1'b0;
    push_kind   = KIND_ACK;
    push_we     = 1'b0;
    push_last   = 1'b0;
    push_l      = '0;
    push_t      = '0;
    push_rt     = '0;
    push_b      = '0;

    unique case (st_r)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_mode)
            MODE_DAMAGE: begin
              push      = 1'b1;
              push_kind = KIND_ACK;
              push_we   = box_empty;
              push_last = 1'b1;
              if (!dmg_empty) begin
                if (box_empty) begin
                  box_l_nxt = dmg_l;
                  box_t_nxt = in_py;
                  box_r_nxt = dmg_r;
                  box_b_nxt = dmg_b;
                end else begin
                  box_l_nxt = (dmg_l < box_l_r) ? dmg_l : box_l_r;
                  box_t_nxt = (in_py < box_t_r) ? in_py : box_t_r;
                  box_r_nxt = (dmg_r > box_r_r) ? dmg_r : box_r_r;
                  box_b_nxt = (dmg_b > box_b_r) ? dmg_b : box_b_r;
                end
              end
            end
            MODE_SAMPLE: begin
              if (ext(in_px) < COL_LIMIT) begin
                st_nxt = ST_SMP;
              end
            end
            MODE_FLUSH: begin
              st_nxt = ST_FSK;
            end
            default: begin
              // unused mode: drop
            end
          endcase
        end
      end

      ST_SMP: begin
        if (!at_head(px_r, hb_r)) begin
          rot = 1'b1;
        end else if (diff_r) begin
          if (!head_open) begin
            ctl.ld      = 1'b1;
            ctl.ld_open = 1'b1;
            ctl.ld_top  = py_r;
          end
          st_nxt = ST_IDLE;
        end else if (head_open) begin
          if (out_free) begin
            push        = 1'b1;
            push_kind   = KIND_RECT;
            push_last   = 1'b1;
            push_l      = px_r;
            push_t      = head_top;
            push_rt     = edge_rt(px_r, box_r_r);
            push_b      = py_r;
            ctl.ld      = 1'b1;
            ctl.ld_open = 1'b0;
            ctl.ld_top  = head_top;
            st_nxt      = ST_IDLE;
          end
        end else begin
          st_nxt = ST_IDLE;
        end
      end

      ST_FSK: begin
        if (box_empty || (ext(box_l_r) >= COL_LIMIT) || at_head(box_l_r, hb_r)) begin
          st_nxt  = ST_FWK;
          cnt_nxt = '0;
          x_nxt   = box_l_r;
        end else begin
          rot = 1'b1;
        end
      end

      ST_FWK: begin
        if (fl_go) begin
          rot     = 1'b1;
          ctl.clr = 1'b1;
          cnt_nxt = cnt_r + 1'b1;
          // advance the walk column along with the head block
          x_nxt   = CW'(ext(x_r) + BW_X);
          if (fl_emit) begin
            if (pend_vld_r) begin
              push      = 1'b1;
              push_kind = KIND_RECT;
              push_l    = pend_l_r;
              push_t    = pend_t_r;
              push_rt   = pend_rt_r;
              push_b    = box_b_r;
            end
            pend_vld_nxt = 1'b1;
            pend_l_nxt   = x_r;
            pend_t_nxt   = head_top;
            pend_rt_nxt  = edge_rt(x_r, box_r_r);
          end
          if (cnt_r == CNT_LAST) begin
            st_nxt = ST_FIN;
          end
        end
      end

      ST_FIN: begin
        if (fin_go) begin
          if (pend_vld_r) begin
            push      = 1'b1;
            push_kind = KIND_RECT;
            push_last = 1'b1;
            push_l    = pend_l_r;
            push_t    = pend_t_r;
            push_rt   = pend_rt_r;
            push_b    = box_b_r;
          end
          pend_vld_nxt = 1'b0;
          box_l_nxt    = '0;
          box_t_nxt    = '0;
          box_r_nxt    = '0;
          box_b_nxt    = '0;
          st_nxt       = ST_IDLE;
        end
      end

      default: begin
        st_nxt = ST_IDLE;
      end
    endcase

    ctl.sh = rot;
    hb_nxt = hb_r;
    if (rot) begin
      hb_nxt = (hb_r + BW_X == COL_LIMIT) ? '0 : hb_r + BW_X;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= ST_IDLE;
      box_l_r    <= '0;
      box_t_r    <= '0;
      box_r_r    <= '0;
      box_b_r    <= '0;
      hb_r       <= '0;
      cnt_r      <= '0;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      st_r       <= st_nxt;
      box_l_r    <= box_l_nxt;
      box_t_r    <= box_t_nxt;
      box_r_r    <= box_r_nxt;
      box_b_r    <= box_b_nxt;
      hb_r       <= hb_nxt;
      cnt_r      <= cnt_nxt;
      pend_vld_r <= pend_vld_nxt;
      if (push) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // payload registers: hold walk column, sample fields, held rectangle and output word
  always_ff @(posedge clk) begin
    x_r       <= x_nxt;
    pend_l_r  <= pend_l_nxt;
    pend_t_r  <= pend_t_nxt;
    pend_rt_r <= pend_rt_nxt;
    if (in_acc) begin
      px_r   <= in_px;
      py_r   <= in_py;
      diff_r <= in_diff;
    end
    if (push) begin
      out_kind_r <= push_kind;
      out_we_r   <= push_we;
      out_last_r <= push_last;
      out_l_r    <= push_l;
      out_t_r    <= push_t;
      out_rt_r   <= push_rt;
      out_b_r    <= push_b;
    end
  end

  ddbt_ring #(
    .NCELL (MAX_BLOCKS)
  ) u_ring (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .head_open (head_open),
    .head_top  (head_top)
  );

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {7'd0, out_b_r, out_rt_r, out_t_r, out_l_r, out_we_r};

  // head block base stays inside the ring
  a_hb_range: assert property (@(posedge clk) disable iff (!rst_n)
    hb_r < COL_LIMIT)
    else $error("head block base out of range");

  // a held rectangle exists only while a flush walks or finishes
  a_pend_state: assert property (@(posedge clk) disable iff (!rst_n)
    pend_vld_r |-> (st_r == ST_FWK || st_r == ST_FIN))
    else $error("held rectangle outside flush");

  // finishing a flush leaves an empty box
  a_fin_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_FIN && fin_go) |=> (box_l_r == '0 && box_r_r == '0 && st_r == ST_IDLE))
    else $error("box not cleared after flush");

  // a damage acknowledge is always the only result of its word
  a_ack_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_kind_r == KIND_ACK) |-> out_last_r)
    else $error("acknowledge without last");

endmodule
`default_nettype wire
